// File: rtl/tsp_pkg.sv
`default_nettype none
package tsp_pkg;

   localparam int NUM_PADS  = 5;
   localparam int PAD_IDX_W = $clog2(NUM_PADS);
   localparam int PAD_WT    = 250;
   localparam int WT_W      = $clog2(PAD_WT * NUM_PADS + 1);
   localparam int WSUM_W    = $clog2(PAD_WT * 255 * NUM_PADS * (NUM_PADS + 1) / 2 + 1);
   localparam int TOT_W     = $clog2(255 * NUM_PADS + 1);
   localparam int DIV_CNT_W = $clog2(WSUM_W);
   localparam int CSR_ADDR_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_START     = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER     = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER     = 8'd3;

   localparam logic [1:0] TAP_ARM   = 2'd0;
   localparam logic [1:0] TAP_WAIT  = 2'd1;
   localparam logic [1:0] TAP_HOLD  = 2'd2;

   typedef struct packed {
      logic [7:0] pad_count_0;
      logic [7:0] pad_count_1;
      logic [7:0] pad_count_2;
      logic [7:0] pad_count_3;
      logic [7:0] pad_count_4;
   } req_data_type;

   typedef struct packed {
      logic signed [10:0] raw_position;
      logic [9:0]         filtered_position;
      logic signed [15:0] scroll_value;
      logic               tap_detected;
      logic               touched;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PADS, ST_FLUSH, ST_DINIT, ST_DIV, ST_POS, ST_GRAD, ST_SCROLL, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic pad_step;
      logic div_init;
      logic div_step;
      logic pos;
      logic grad;
      logic scroll;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic pad_last;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/tsp_ctrl.sv
`default_nettype none
module tsp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  tsp_pkg::status_type status,
   output tsp_pkg::cmd_type    cmd
);
   import tsp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PADS;
            end
         end
         ST_PADS: begin
            cmd.pad_step = 1'b1;
            if (status.pad_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: state_in = ST_DINIT;
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_POS;
         end
         ST_POS: begin
            cmd.pos = 1'b1;
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SCROLL;
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/tsp_dpath.sv
`default_nettype none
module tsp_dpath (
   input  wire                              clock,
   input  wire                              reset,
   input  tsp_pkg::cmd_type                 cmd,
   output tsp_pkg::status_type              status,
   input  tsp_pkg::req_data_type            req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output tsp_pkg::rsp_data_type            rsp_data,
   input  wire                              csr_we,
   input  wire [tsp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire [15:0]                       csr_wdata
);
   import tsp_pkg::*;

   // configuration
   logic [10:0]        thr_ff;
   logic signed [15:0] lower_ff, upper_ff;
   logic signed [21:0] acc_ff, acc_in;

   // per-scan pad pass
   logic [7:0]           cnt_ff [NUM_PADS];
   logic [15:0]          base_ff [NUM_PADS];
   logic [PAD_IDX_W-1:0] idx_ff;
   logic [7:0]           lvl_ff;
   logic [WT_W-1:0]      wt_ff;
   logic                 lvl_vld_ff;
   logic [WSUM_W-1:0]    wsum_ff;
   logic [TOT_W-1:0]     tot_ff;

   // divider
   logic [WSUM_W-1:0]    quo_ff;
   logic [TOT_W-1:0]     rem_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;

   // tracking state
   logic               touched_ff, released_ff, tap_ff;
   logic signed [10:0] raw_ff;
   logic [9:0]         sp_ff, prev_ff;
   logic signed [10:0] sg_ff;
   logic [1:0]         phase_ff;
   logic [7:0]         dur_ff;

   logic         out_vld_ff;
   rsp_data_type out_ff;

   // pad step logic
   logic [7:0]  cnt_cur;
   logic [15:0] base_cur, cnt100, bmin, b1;
   logic [31:0] recip;
   logic [9:0]  q100;
   logic [7:0]  lvl_cur;

   always_comb begin
      cnt_cur  = cnt_ff[idx_ff];
      base_cur = base_ff[idx_ff];
      cnt100   = 16'(cnt_cur) * 16'd100;
      bmin     = (cnt100 < base_cur) ? cnt100 : base_cur;
      b1       = bmin + 16'd1;
      // divide by 100 via reciprocal 2^22/100 rounded up
      recip    = 32'(b1) * 32'd41944;
      q100     = recip[31:22];
      lvl_cur  = (10'(cnt_cur) >= q100) ? 8'(10'(cnt_cur) - q100) : 8'd0;
   end

   // divider step
   logic [TOT_W:0] dsh, ddiff;
   always_comb begin
      dsh   = {rem_ff, quo_ff[WSUM_W-1]};
      ddiff = dsh - {1'b0, tot_ff};
   end

   // position logic
   logic               touch_now;
   logic [WSUM_W-1:0]  raw_w;
   logic signed [10:0] raw_now;
   logic [12:0]        sp_sum;
   logic [9:0]         sp_smooth;
   logic               win;

   always_comb begin
      touch_now = (tot_ff > TOT_W'(thr_ff)) && (tot_ff != '0);
      raw_w     = quo_ff - WSUM_W'(PAD_WT);
      raw_now   = touch_now ? signed'(raw_w[10:0]) : -11'sd1;
      sp_sum    = 13'(sp_ff) * 13'd3 + 13'(raw_w[9:0]) + 13'd2;
      sp_smooth = (sp_ff == '0) ? raw_w[9:0] : sp_sum[11:2];
      win       = touch_now && (raw_w[10:0] > 11'd400) && (raw_w[10:0] < 11'd600);
   end

   // gradient logic
   logic signed [10:0] grad;
   logic signed [13:0] sg_sum, sg_adj;
   logic signed [10:0] sg_smooth;
   always_comb begin
      grad      = signed'({1'b0, sp_ff}) - signed'({1'b0, prev_ff});
      sg_sum    = 14'(sg_ff) * 14'sd3 + 14'(grad) + 14'sd2;
      // truncate toward zero
      sg_adj    = sg_sum[13] ? (sg_sum + 14'sd3) >>> 2 : sg_sum >>> 2;
      sg_smooth = (sg_ff == '0) ? grad : sg_adj[10:0];
   end

   // scroll logic
   logic signed [22:0] diff, lo, hi, clamped;
   logic               do_scroll;
   logic signed [21:0] acc_adj;
   always_comb begin
      do_scroll = touched_ff || (sg_ff > 11'sd30) || (sg_ff < -11'sd30);
      diff      = 23'(acc_ff) - 23'(sg_ff);
      lo        = 23'(signed'({lower_ff, 5'b0}));
      hi        = 23'(signed'({upper_ff, 5'b0}));
      if (diff < lo) clamped = lo;
      else if (diff > hi) clamped = hi;
      else clamped = diff;
      acc_in = acc_ff;
      if (csr_we && csr_addr == CSR_START) acc_in = 22'(signed'({csr_wdata, 5'b0}));
      else if (cmd.scroll && do_scroll) acc_in = clamped[21:0];
      acc_adj = acc_ff[21] ? acc_ff + 22'sd31 : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 11'd15;
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_THRESHOLD: thr_ff   <= csr_wdata[10:0];
            CSR_LOWER:     lower_ff <= csr_wdata;
            CSR_UPPER:     upper_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff[0] <= req_data.pad_count_0;
         cnt_ff[1] <= req_data.pad_count_1;
         cnt_ff[2] <= req_data.pad_count_2;
         cnt_ff[3] <= req_data.pad_count_3;
         cnt_ff[4] <= req_data.pad_count_4;
      end
      if (cmd.pad_step) begin
         lvl_ff <= lvl_cur;
         wt_ff  <= WT_W'((32'(idx_ff) + 32'd1) * PAD_WT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PADS; i++) base_ff[i] <= 16'hFFFF;
         idx_ff     <= '0;
         lvl_vld_ff <= 1'b0;
         wsum_ff    <= '0;
         tot_ff     <= '0;
      end else begin
         lvl_vld_ff <= cmd.pad_step;
         if (cmd.load) begin
            idx_ff  <= '0;
            wsum_ff <= '0;
            tot_ff  <= '0;
         end else begin
            if (cmd.pad_step) begin
               base_ff[idx_ff] <= b1;
               idx_ff <= idx_ff + 1'b1;
            end
            if (lvl_vld_ff) begin
               wsum_ff <= wsum_ff + WSUM_W'(wt_ff * lvl_ff);
               tot_ff  <= tot_ff + TOT_W'(lvl_ff);
            end
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_init) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quo_ff <= wsum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!ddiff[TOT_W]) begin
            rem_ff <= ddiff[TOT_W-1:0];
            quo_ff <= {quo_ff[WSUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= dsh[TOT_W-1:0];
            quo_ff <= {quo_ff[WSUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff  <= 1'b0;
         released_ff <= 1'b0;
         tap_ff      <= 1'b0;
         raw_ff      <= '0;
         sp_ff       <= '0;
         prev_ff     <= '0;
         sg_ff       <= '0;
         phase_ff    <= TAP_ARM;
         dur_ff      <= '0;
      end else begin
         if (cmd.pos) begin
            touched_ff <= touch_now;
            raw_ff     <= raw_now;
            tap_ff     <= 1'b0;
            if (touch_now) begin
               released_ff <= 1'b0;
               if (released_ff) begin
                  sp_ff   <= raw_w[9:0];
                  prev_ff <= raw_w[9:0];
                  sg_ff   <= '0;
               end else begin
                  sp_ff <= sp_smooth;
               end
            end else begin
               released_ff <= 1'b1;
            end
            case (phase_ff)
               TAP_ARM: begin
                  dur_ff <= '0;
                  if (!touch_now) phase_ff <= TAP_WAIT;
               end
               TAP_WAIT: begin
                  if (touch_now) begin
                     dur_ff <= '0;
                     if (win) phase_ff <= TAP_HOLD;
                  end
               end
               TAP_HOLD: begin
                  if (win) begin
                     dur_ff <= dur_ff + 8'd1;
                  end else if (!touch_now) begin
                     if (dur_ff > 8'd1 && dur_ff < 8'd6) begin
                        tap_ff   <= 1'b1;
                        phase_ff <= TAP_ARM;
                     end
                  end else begin
                     phase_ff <= TAP_ARM;
                  end
               end
               default: phase_ff <= TAP_ARM;
            endcase
         end
         if (cmd.grad && touched_ff) begin
            prev_ff <= sp_ff;
            sg_ff   <= sg_smooth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.raw_position      <= raw_ff;
         out_ff.filtered_position <= sp_ff;
         out_ff.scroll_value      <= acc_adj[20:5];
         out_ff.tap_detected      <= tap_ff;
         out_ff.touched           <= touched_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_data        = out_ff;
   assign status.pad_last = (idx_ff == PAD_IDX_W'(NUM_PADS - 1));
   assign status.div_last = (dcnt_ff == DIV_CNT_W'(WSUM_W - 1));
   assign status.out_busy = out_vld_ff && rsp_stall;

endmodule
`default_nettype wire

// File: rtl/touch_slider_processor.sv
`default_nettype none
// Touch slider processor: each accepted item carries one scan of five pad counts and
// produces one result with the centroid position, the smoothed position, the scroll
// value and tap/touch flags. After acceptance an item goes through these steps in order:
// a pass over the pads to update the baselines and take the levels, a flush of the
// level sum, the setup of a restoring divider that then yields one quotient bit per
// cycle for the centroid, then filter and tap update, gradient, scroll update and
// output load. The result sits in an output register, so the next scan is taken while
// it waits; a result still stalled there delays the output load of the following
// item. Configuration writes take effect at once and belong in idle time.
module touch_slider_processor (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  tsp_pkg::req_data_type            req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output tsp_pkg::rsp_data_type            rsp_data,
   input  wire                              csr_we,
   input  wire [tsp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire [15:0]                       csr_wdata
);
   import tsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire
